/* sv/l2n_pkg.sv */
// l2n_pkg: shared types, register indexes, reset values and widths for the
// L2 normalizer. No dependencies; l2n_front, l2n_back and the top level refer to it by scoped name.
`timescale 1ns / 1ps

package l2n_pkg;

  localparam int MAX_CHANNELS_DEF = 64;

  localparam int CODE_W     = 8;
  localparam int VLEN_W     = 7;
  localparam int ZERO_W     = 8;
  localparam int INV_W      = 24;
  localparam int OFF_W      = 9;
  localparam int SQ_W       = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  // Rounding search: q is 0..256, tested one bit at a time from the top.
  localparam int Q_W        = 9;
  localparam int Q_MAX      = 256;
  localparam int RSQ_SHIFT  = 22;
  localparam int OUT_MAX    = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VECTOR_LENGTH    = 8'd0,
    REG_INPUT_ZERO       = 8'd1,
    REG_OUTPUT_ZERO      = 8'd2,
    REG_OUTPUT_INV_SCALE = 8'd3
  } cfg_reg_e;

  localparam logic [VLEN_W-1:0] VECTOR_LENGTH_RST    = 7'd64;
  localparam logic [ZERO_W-1:0] INPUT_ZERO_RST       = 8'd128;
  localparam logic [ZERO_W-1:0] OUTPUT_ZERO_RST      = 8'd128;
  localparam logic [INV_W-1:0]  OUTPUT_INV_SCALE_RST = 24'd524288;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_MAG  = 7'b0000100,
    ST_SQA  = 7'b0001000,
    ST_SQD  = 7'b0010000,
    ST_CMP  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } back_state_e;

endpackage

/* sv/l2n_ram.sv */
// l2n_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module l2n_ram #(
  parameter int W     = 9,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/l2n_desc_fifo.sv */
// l2n_desc_fifo: two-entry queue of finished-vector descriptors between the
// front and back parts. No dependencies.
`timescale 1ns / 1ps

module l2n_desc_fifo #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic [1:0]   count_o
);

  logic [W-1:0] ent_q [2];
  logic         wr_q, wr_d;
  logic         rd_q, rd_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_push, do_pop;

  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign rdata_o = ent_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* sv/l2n_front.sv */
// l2n_front: accepts input codes, stores offsets, accumulates the sum of
// squares and closes vectors. Depends on l2n_pkg.
`timescale 1ns / 1ps

module l2n_front #(
  parameter int MAX_CHANNELS = l2n_pkg::MAX_CHANNELS_DEF,
  parameter int IW           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int CW           = $clog2(MAX_CHANNELS + 1),
  parameter int SW           = l2n_pkg::SQ_W + $clog2(MAX_CHANNELS) + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        stall_i,
  input  logic [l2n_pkg::CODE_W-1:0]  in_code_i,
  input  logic [l2n_pkg::VLEN_W-1:0]  vector_length_i,
  input  logic [l2n_pkg::ZERO_W-1:0]  input_zero_i,
  output logic                        we_o,
  output logic [IW:0]                 waddr_o,
  output logic [l2n_pkg::OFF_W-1:0]   wdata_o,
  output logic                        desc_push_o,
  output logic [SW+CW:0]              desc_o
);

  localparam int LW = (CW > l2n_pkg::VLEN_W) ? CW : l2n_pkg::VLEN_W;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_CHANNELS);

  logic                      accept;
  logic signed [l2n_pkg::OFF_W-1:0] off;
  logic signed [2*l2n_pkg::OFF_W-1:0] sq_full;
  logic [l2n_pkg::SQ_W-1:0]  sq;
  logic [CW-1:0]             cnt_q, cnt_d, cnt_nxt;
  logic [SW-1:0]             sum_q, sum_d, sum_nxt;
  logic                      bank_q, bank_d;
  logic [LW-1:0]             vlen, len_eff;
  logic                      done;

  assign accept  = push_i && !stall_i;
  assign off     = $signed({1'b0, in_code_i}) - $signed({1'b0, input_zero_i});
  assign sq_full = off * off;
  assign sq      = sq_full[l2n_pkg::SQ_W-1:0];
  assign cnt_nxt = cnt_q + CW'(1);
  assign sum_nxt = sum_q + SW'(sq);

  // Clamp the programmed length to 1..MAX_CHANNELS.
  always_comb begin
    vlen = LW'(vector_length_i);
    if (vlen == '0) begin
      len_eff = LW'(1);
    end else if (vlen > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = vlen;
    end
  end

  assign done        = LW'(cnt_nxt) >= len_eff;
  assign we_o        = accept;
  assign waddr_o     = {bank_q, cnt_q[IW-1:0]};
  assign wdata_o     = off;
  assign desc_push_o = accept && done;
  assign desc_o      = {bank_q, cnt_nxt, sum_nxt};

  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    bank_d = bank_q;
    if (accept) begin
      if (done) begin
        cnt_d  = '0;
        sum_d  = '0;
        bank_d = !bank_q;
      end else begin
        cnt_d = cnt_nxt;
        sum_d = sum_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      bank_q <= bank_d;
    end
  end

endmodule

/* sv/l2n_back.sv */
// l2n_back: reads back each stored offset of a finished vector, scales it by
// rsqrt(sum) with an exact rounding search and holds the result for the
// consumer. Depends on l2n_pkg.
`timescale 1ns / 1ps

module l2n_back #(
  parameter int MAX_CHANNELS = l2n_pkg::MAX_CHANNELS_DEF,
  parameter int IW           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  parameter int CW           = $clog2(MAX_CHANNELS + 1),
  parameter int SW           = l2n_pkg::SQ_W + $clog2(MAX_CHANNELS) + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       desc_avail_i,
  input  logic [SW+CW:0]             desc_i,
  output logic                       desc_pop_o,
  output logic                       busy_o,
  output logic                       re_o,
  output logic [IW:0]                raddr_o,
  input  logic [l2n_pkg::OFF_W-1:0]  rdata_i,
  input  logic [l2n_pkg::ZERO_W-1:0] output_zero_i,
  input  logic [l2n_pkg::INV_W-1:0]  output_inv_scale_i,
  input  logic                       pop,
  output logic                       empty,
  output logic [l2n_pkg::CODE_W-1:0] out_code_o,
  output logic                       out_last_o
);

  localparam int AW   = l2n_pkg::CODE_W + l2n_pkg::INV_W;
  localparam int LIMW = 2 * AW - l2n_pkg::RSQ_SHIFT;
  localparam int DW   = 2 * l2n_pkg::Q_W + 2;
  localparam int PW   = DW + SW;
  localparam int CMPW = (PW > LIMW) ? PW : LIMW;

  l2n_pkg::back_state_e state_q, state_d;

  logic [SW-1:0]             sum_q, sum_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [CW-1:0]             k_q, k_d;
  logic                      bank_q, bank_d;
  logic                      neg_q, neg_d;
  logic [AW-1:0]             a_q, a_d;
  logic [LIMW-1:0]           lim_q, lim_d;
  logic [l2n_pkg::Q_W-1:0]   q_q, q_d;
  logic [3:0]                bi_q, bi_d;
  logic [DW-1:0]             dsq_q, dsq_d;
  logic                      tok_q, tok_d;
  logic                      ov_q, ov_d;
  logic [l2n_pkg::CODE_W-1:0] oc_q, oc_d;
  logic                      ol_q, ol_d;

  logic signed [l2n_pkg::OFF_W-1:0] off;
  logic [l2n_pkg::CODE_W-1:0] mag;
  logic [2*AW-1:0]           asq;
  logic [l2n_pkg::Q_W-1:0]   trial;
  logic [l2n_pkg::Q_W:0]     dval;
  logic [PW-1:0]             prod;
  logic                      fits;
  logic signed [l2n_pkg::Q_W+2:0] rsum;
  logic [l2n_pkg::CODE_W-1:0] rclamp;
  logic                      last;
  logic                      out_free;

  assign off      = $signed(rdata_i);
  assign mag      = off[l2n_pkg::OFF_W-1] ? l2n_pkg::CODE_W'(-off)
                                          : off[l2n_pkg::CODE_W-1:0];
  assign asq      = a_q * a_q;
  assign trial    = q_q | (l2n_pkg::Q_W'(1) << bi_q);
  assign dval     = {trial, 1'b0} - (l2n_pkg::Q_W+1)'(1);
  assign prod     = dsq_q * sum_q;
  assign fits     = tok_q && (sum_q != '0) && (CMPW'(prod) <= CMPW'(lim_q));
  assign last     = (k_q + CW'(1)) == cnt_q;
  assign out_free = !ov_q || pop;

  // Add the signed magnitude to the zero point and clamp to a byte.
  always_comb begin
    if (neg_q) begin
      rsum = $signed({4'b0000, output_zero_i}) - $signed({3'b000, q_q});
    end else begin
      rsum = $signed({4'b0000, output_zero_i}) + $signed({3'b000, q_q});
    end
    if (rsum < 0) begin
      rclamp = '0;
    end else if (rsum > (l2n_pkg::Q_W+3)'(l2n_pkg::OUT_MAX)) begin
      rclamp = l2n_pkg::CODE_W'(l2n_pkg::OUT_MAX);
    end else begin
      rclamp = rsum[l2n_pkg::CODE_W-1:0];
    end
  end

  assign busy_o     = (state_q != l2n_pkg::ST_IDLE);
  assign desc_pop_o = (state_q == l2n_pkg::ST_IDLE) && desc_avail_i;
  assign re_o       = (state_q == l2n_pkg::ST_READ);
  assign raddr_o    = {bank_q, k_q[IW-1:0]};
  assign empty      = !ov_q;
  assign out_code_o = oc_q;
  assign out_last_o = ol_q;

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    bank_d  = bank_q;
    neg_d   = neg_q;
    a_d     = a_q;
    lim_d   = lim_q;
    q_d     = q_q;
    bi_d    = bi_q;
    dsq_d   = dsq_q;
    tok_d   = tok_q;
    ov_d    = ov_q && !pop;
    oc_d    = oc_q;
    ol_d    = ol_q;
    case (state_q)
      l2n_pkg::ST_IDLE: begin
        if (desc_avail_i) begin
          {bank_d, cnt_d, sum_d} = desc_i;
          k_d     = '0;
          state_d = l2n_pkg::ST_READ;
        end
      end
      l2n_pkg::ST_READ: begin
        state_d = l2n_pkg::ST_MAG;
      end
      l2n_pkg::ST_MAG: begin
        neg_d   = off[l2n_pkg::OFF_W-1];
        a_d     = mag * output_inv_scale_i;
        state_d = l2n_pkg::ST_SQA;
      end
      l2n_pkg::ST_SQA: begin
        lim_d   = asq[2*AW-1:l2n_pkg::RSQ_SHIFT];
        q_d     = '0;
        bi_d    = 4'(l2n_pkg::Q_W - 1);
        state_d = l2n_pkg::ST_SQD;
      end
      l2n_pkg::ST_SQD: begin
        dsq_d   = dval * dval;
        tok_d   = trial <= l2n_pkg::Q_W'(l2n_pkg::Q_MAX);
        state_d = l2n_pkg::ST_CMP;
      end
      l2n_pkg::ST_CMP: begin
        if (fits) begin
          q_d = trial;
        end
        if (bi_q == '0) begin
          state_d = l2n_pkg::ST_OUT;
        end else begin
          bi_d    = bi_q - 4'd1;
          state_d = l2n_pkg::ST_SQD;
        end
      end
      l2n_pkg::ST_OUT: begin
        if (out_free) begin
          ov_d = 1'b1;
          oc_d = rclamp;
          ol_d = last;
          if (last) begin
            state_d = l2n_pkg::ST_IDLE;
          end else begin
            k_d     = k_q + CW'(1);
            state_d = l2n_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_d = l2n_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= l2n_pkg::ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    cnt_q  <= cnt_d;
    k_q    <= k_d;
    bank_q <= bank_d;
    neg_q  <= neg_d;
    a_q    <= a_d;
    lim_q  <= lim_d;
    q_q    <= q_d;
    bi_q   <= bi_d;
    dsq_q  <= dsq_d;
    tok_q  <= tok_d;
    oc_q   <= oc_d;
    ol_q   <= ol_d;
  end

endmodule

/* sv/l2_normalize_uint8_vector.sv */
// l2_normalize_uint8_vector: top level of the quantized L2 normalizer.
// Depends on l2n_pkg, l2n_ram, l2n_desc_fifo, l2n_front and l2n_back.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     push / full             in_code_i
// result    pop / empty             out_code_o, out_last_o
// config    cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The front takes one element per cycle while fewer than two finished vectors
// wait for or occupy the back; the offset RAM has two banks for this.
// For each result the back does one RAM read, two multiplies and a
// nine-step rounding search, each step a square and a multiply-compare.
// Reset clears counters, handshake state and registers to their defaults.
// Full holds while two vectors are in flight; the back stalls on a held result.

module l2_normalize_uint8_vector #(
  parameter int MAX_CHANNELS = l2n_pkg::MAX_CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [l2n_pkg::CODE_W-1:0]     in_code_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [l2n_pkg::CODE_W-1:0]     out_code_o,
  output logic                           out_last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [l2n_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [l2n_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int SW = l2n_pkg::SQ_W + $clog2(MAX_CHANNELS) + 1;
  localparam int DEPTH = 2 ** (IW + 1);

  logic [l2n_pkg::VLEN_W-1:0] vlen_q, vlen_d;
  logic [l2n_pkg::ZERO_W-1:0] izero_q, izero_d;
  logic [l2n_pkg::ZERO_W-1:0] ozero_q, ozero_d;
  logic [l2n_pkg::INV_W-1:0]  inv_q, inv_d;

  logic                      we, re;
  logic [IW:0]               waddr, raddr;
  logic [l2n_pkg::OFF_W-1:0] wdata, rdata;
  logic                      desc_push, desc_pop, busy;
  logic [SW+CW:0]            desc_in, desc_out;
  logic [1:0]                desc_cnt;
  logic [2:0]                in_flight;

  // Registers always take the request.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    vlen_d  = vlen_q;
    izero_d = izero_q;
    ozero_d = ozero_q;
    inv_d   = inv_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        l2n_pkg::REG_VECTOR_LENGTH:    vlen_d  = cfg_data_i[l2n_pkg::VLEN_W-1:0];
        l2n_pkg::REG_INPUT_ZERO:       izero_d = cfg_data_i[l2n_pkg::ZERO_W-1:0];
        l2n_pkg::REG_OUTPUT_ZERO:      ozero_d = cfg_data_i[l2n_pkg::ZERO_W-1:0];
        l2n_pkg::REG_OUTPUT_INV_SCALE: inv_d   = cfg_data_i[l2n_pkg::INV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q  <= l2n_pkg::VECTOR_LENGTH_RST;
      izero_q <= l2n_pkg::INPUT_ZERO_RST;
      ozero_q <= l2n_pkg::OUTPUT_ZERO_RST;
      inv_q   <= l2n_pkg::OUTPUT_INV_SCALE_RST;
    end else begin
      vlen_q  <= vlen_d;
      izero_q <= izero_d;
      ozero_q <= ozero_d;
      inv_q   <= inv_d;
    end
  end

  // Two vectors in flight fill both RAM banks: hold the input side.
  assign in_flight = 3'(desc_cnt) + 3'(busy);
  assign full      = in_flight >= 3'd2;

  l2n_front #(
    .MAX_CHANNELS(MAX_CHANNELS), .IW(IW), .CW(CW), .SW(SW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .stall_i         (full),
    .in_code_i       (in_code_i),
    .vector_length_i (vlen_q),
    .input_zero_i    (izero_q),
    .we_o            (we),
    .waddr_o         (waddr),
    .wdata_o         (wdata),
    .desc_push_o     (desc_push),
    .desc_o          (desc_in)
  );

  l2n_desc_fifo #(
    .W(SW + CW + 1)
  ) u_desc_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .wdata_i (desc_in),
    .pop_i   (desc_pop),
    .rdata_o (desc_out),
    .count_o (desc_cnt)
  );

  l2n_ram #(
    .W(l2n_pkg::OFF_W), .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  l2n_back #(
    .MAX_CHANNELS(MAX_CHANNELS), .IW(IW), .CW(CW), .SW(SW)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .desc_avail_i       (desc_cnt != 2'd0),
    .desc_i             (desc_out),
    .desc_pop_o         (desc_pop),
    .busy_o             (busy),
    .re_o               (re),
    .raddr_o            (raddr),
    .rdata_i            (rdata),
    .output_zero_i      (ozero_q),
    .output_inv_scale_i (inv_q),
    .pop                (pop),
    .empty              (empty),
    .out_code_o         (out_code_o),
    .out_last_o         (out_last_o)
  );

endmodule
